### src/tfrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer function ramp lookup package
// Shared types and fixed constants for the RGBA ramp lookup block.
// ----------------------------------------------------------------------------
package tfrl_pkg;

  // Q1.15 value for 1.0.
  localparam int unsigned ONE_Q15    = 32768;
  // Number of table entries spanning the axis from 0 up to, but not including, 1.0.
  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned TBL_SHIFT  = $clog2(TABLE_SIZE);
  // Fixed widths of the item fields.
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CNT_W      = 5;
  // Magnitude width of a component product, which is also the divide length.
  localparam int unsigned PROD_W     = 32;

  // Item commands.
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } tfrl_cmd_t;

  // One control point as held in the store.
  typedef struct packed {
    logic [VAL_W-1:0] pos;
    logic [VAL_W-1:0] opa;
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] grn;
    logic [VAL_W-1:0] blu;
  } tfrl_point_t;

  // Classified item passed from the front to the back.
  typedef struct packed {
    logic              is_load;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot;
    tfrl_point_t       pt;
    logic [VAL_W-1:0]  x;
  } tfrl_item_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOADA,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } tfrl_state_t;

endpackage

### src/tfrl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one load or evaluate item.
// ----------------------------------------------------------------------------
interface tfrl_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  cmd;
  logic [3:0]  slot;
  logic [15:0] point_position;
  logic [15:0] point_opacity;
  logic [15:0] point_red;
  logic [15:0] point_green;
  logic [15:0] point_blue;
  logic [7:0]  entry_index;

  modport source (output valid, cmd, slot, point_position, point_opacity, point_red,
                  point_green, point_blue, entry_index, input ready);
  modport sink   (input valid, cmd, slot, point_position, point_opacity, point_red,
                  point_green, point_blue, entry_index, output ready);
endinterface

### src/tfrl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one interpolated RGBA item.
// ----------------------------------------------------------------------------
interface tfrl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [15:0] out_opacity;

  modport source (output valid, out_red, out_green, out_blue, out_opacity, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_opacity, output ready);
endinterface

### src/tfrl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tfrl_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

### src/tfrl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tfrl_front #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  tfrl_in_if.sink             in_ch,
  output logic                q_valid,
  output tfrl_pkg::tfrl_item_t q_item,
  input  logic                q_pop
);
  localparam int unsigned SLOT_W = tfrl_pkg::SLOT_W;

  tfrl_pkg::tfrl_item_t entry_r [2];
  tfrl_pkg::tfrl_item_t item_in;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r,  count_nxt;
  logic       push;
  logic       pop;
  logic [23:0] x_wide;

  assign in_ch.ready = (count_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != 2'd0);
  assign pop         = q_pop && q_valid;
  assign q_item      = entry_r[rd_ptr_r];

  // Classify the incoming item and work out its axis position.
  always_comb begin
    x_wide          = (24'(in_ch.entry_index) << 15) >> tfrl_pkg::TBL_SHIFT;
    item_in.is_load = (in_ch.cmd == 1'(tfrl_pkg::CMD_LOAD));
    item_in.slot_ok = ((SLOT_W + 8)'(in_ch.slot) < (SLOT_W + 8)'(MAX_POINTS));
    item_in.slot    = in_ch.slot;
    item_in.pt.pos  = in_ch.point_position;
    item_in.pt.opa  = in_ch.point_opacity;
    item_in.pt.red  = in_ch.point_red;
    item_in.pt.grn  = in_ch.point_green;
    item_in.pt.blu  = in_ch.point_blue;
    item_in.x       = x_wide[15:0];
  end

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item_in;
    end
  end
endmodule

### src/tfrl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Writes control points, scans for the segment, interpolates four lanes
// with per-lane bit-serial divides by a shared divisor and drives the result register.
// ----------------------------------------------------------------------------
module tfrl_back #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [4:0]           points_in_use,
  input  logic                 q_valid,
  input  tfrl_pkg::tfrl_item_t q_item,
  output logic                 q_pop,
  tfrl_out_if.source           out_ch
);
  localparam int unsigned AW     = $clog2(MAX_POINTS);
  localparam int unsigned NW     = $clog2(MAX_POINTS + 1) + 1;
  localparam int unsigned VW     = tfrl_pkg::VAL_W;
  localparam int unsigned PW     = tfrl_pkg::PROD_W;
  localparam int unsigned CW     = tfrl_pkg::CNT_W;
  localparam int unsigned LANES  = 4;

  tfrl_pkg::tfrl_state_t state_r, state_nxt;
  tfrl_pkg::tfrl_point_t rd_pt, a_r, b_r;

  logic [AW-1:0]  p_r, p_nxt;
  logic [NW-1:0]  n_r, n_nxt;
  logic [VW-1:0]  x_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  raddr;
  logic           ram_we;
  logic           advance;
  logic           finish;
  logic           out_free;
  logic           zero_seg_r;
  logic [VW-1:0]  den_r;

  // Per-lane divider state: lane 0 red, 1 green, 2 blue, 3 opacity.
  logic [VW-1:0]  v0_r  [LANES];
  logic           neg_r [LANES];
  logic [PW-1:0]  qn_r  [LANES];
  logic [VW-1:0]  rem_r [LANES];
  logic [VW-1:0]  res   [LANES];

  logic           out_valid_r, out_valid_nxt;
  logic [VW-1:0]  out_r [LANES];

  tfrl_ram #(
    .WIDTH ($bits(tfrl_pkg::tfrl_point_t)),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(q_item.slot)),
    .wdata (q_item.pt),
    .raddr (raddr),
    .rdata (rd_pt)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign advance  = ((NW + 1)'(p_r) + (NW + 1)'(2) < (NW + 1)'(n_r)) && (x_r > rd_pt.pos);
  assign finish   = (state_r == tfrl_pkg::ST_DONE) && out_free;

  // Clamp the point count into the supported range.
  always_comb begin
    if (points_in_use < 5'd2) begin
      n_nxt = NW'(2);
    end else if ((NW + 5)'(points_in_use) > (NW + 5)'(MAX_POINTS)) begin
      n_nxt = NW'(MAX_POINTS);
    end else begin
      n_nxt = NW'(points_in_use);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfrl_pkg::ST_IDLE: begin
        if (q_valid && !q_item.is_load) begin
          state_nxt = tfrl_pkg::ST_SCAN;
        end
      end
      tfrl_pkg::ST_SCAN: begin
        if (!advance) begin
          state_nxt = tfrl_pkg::ST_LOADA;
        end
      end
      tfrl_pkg::ST_LOADA: state_nxt = tfrl_pkg::ST_MUL;
      tfrl_pkg::ST_MUL:   state_nxt = tfrl_pkg::ST_DIV;
      tfrl_pkg::ST_DIV: begin
        if (cnt_r == CW'(PW - 1)) begin
          state_nxt = tfrl_pkg::ST_DONE;
        end
      end
      tfrl_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = tfrl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tfrl_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    q_pop   = 1'b0;
    ram_we  = 1'b0;
    raddr   = AW'(1);
    p_nxt   = p_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      tfrl_pkg::ST_IDLE: begin
        q_pop  = q_valid;
        ram_we = q_valid && q_item.is_load && q_item.slot_ok;
        p_nxt  = '0;
      end
      tfrl_pkg::ST_SCAN: begin
        if (advance) begin
          p_nxt = p_r + AW'(1);
          raddr = p_r + AW'(2);
        end else begin
          raddr = p_r;
        end
      end
      tfrl_pkg::ST_MUL: cnt_nxt = '0;
      tfrl_pkg::ST_DIV: cnt_nxt = cnt_r + CW'(1);
      default: ;
    endcase
  end

  // Result register toward the output channel.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tfrl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan registers and segment end points.
  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    cnt_r <= cnt_nxt;
    if (state_r == tfrl_pkg::ST_IDLE) begin
      x_r <= q_item.x;
      n_r <= n_nxt;
    end
    if (state_r == tfrl_pkg::ST_SCAN && !advance) begin
      b_r <= rd_pt;
    end
    if (state_r == tfrl_pkg::ST_LOADA) begin
      a_r <= rd_pt;
    end
  end

  // Lane datapath: product, then restoring division one bit per cycle.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [VW-1:0]        v0;
    logic [VW-1:0]        v1;
    logic signed [VW:0]   diff;
    logic signed [VW:0]   dx;
    logic signed [2*VW+1:0] prod;
    logic [VW:0]          rem_sh;
    logic signed [PW+1:0] q_s;
    logic signed [PW+3:0] v_s;

    always_comb begin
      unique case (l)
        0:       begin v0 = a_r.red; v1 = b_r.red; end
        1:       begin v0 = a_r.grn; v1 = b_r.grn; end
        2:       begin v0 = a_r.blu; v1 = b_r.blu; end
        default: begin v0 = a_r.opa; v1 = b_r.opa; end
      endcase
      diff   = $signed({1'b0, v1}) - $signed({1'b0, v0});
      dx     = $signed({1'b0, x_r}) - $signed({1'b0, a_r.pos});
      prod   = (2*VW+2)'(diff) * (2*VW+2)'(dx);
      rem_sh = {rem_r[l], qn_r[l][PW-1]};
      // Floor of the signed quotient, then add to the left value and clamp.
      if (neg_r[l]) begin
        q_s = -$signed({2'b00, qn_r[l]}) - $signed((PW+2)'(rem_r[l] != '0));
      end else begin
        q_s = $signed({2'b00, qn_r[l]});
      end
      v_s = $signed((PW+4)'(v0_r[l])) + (zero_seg_r ? '0 : (PW+4)'(q_s));
      if (v_s < 0) begin
        res[l] = '0;
      end else if (v_s > (PW+4)'(tfrl_pkg::ONE_Q15)) begin
        res[l] = VW'(tfrl_pkg::ONE_Q15);
      end else begin
        res[l] = v_s[VW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (state_r == tfrl_pkg::ST_MUL) begin
        v0_r[l]  <= v0;
        neg_r[l] <= prod[2*VW+1];
        qn_r[l]  <= prod[2*VW+1] ? PW'(-prod) : PW'(prod);
        rem_r[l] <= '0;
      end else if (state_r == tfrl_pkg::ST_DIV) begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r[l] <= VW'(rem_sh - {1'b0, den_r});
          qn_r[l]  <= {qn_r[l][PW-2:0], 1'b1};
        end else begin
          rem_r[l] <= rem_sh[VW-1:0];
          qn_r[l]  <= {qn_r[l][PW-2:0], 1'b0};
        end
      end
      if (finish) begin
        out_r[l] <= res[l];
      end
    end
  end

  // Segment length; a zero-length or reversed segment keeps the left point.
  always_ff @(posedge clk) begin
    if (state_r == tfrl_pkg::ST_MUL) begin
      zero_seg_r <= (b_r.pos <= a_r.pos);
      den_r      <= b_r.pos - a_r.pos;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_red     = out_r[0];
  assign out_ch.out_green   = out_r[1];
  assign out_ch.out_blue    = out_r[2];
  assign out_ch.out_opacity = out_r[3];
endmodule

### src/transfer_function_ramp_lookup_unit.sv
// Order: a load leaves the queue and is written in the back end's idle state; an
// evaluate leaves the queue, scans past 0 to points-2 segments, loads the left point,
// multiplies, runs the 32-step bit-serial divides of the four lanes and then offers the
// result. The back end takes one item at a time; a 2-entry queue decouples input.
// Reset: synchronous active-low rst_n clears control state, sets the point count
// to 2; the control point store is undefined until loaded.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer function ramp lookup unit
// Piecewise-linear RGBA transfer function over loaded control points.
// ----------------------------------------------------------------------------
module transfer_function_ramp_lookup_unit #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  tfrl_in_if.sink    in_ch,
  tfrl_out_if.source out_ch
);
  logic                 q_valid;
  logic                 q_pop;
  tfrl_pkg::tfrl_item_t q_item;
  logic [4:0]           points_r, points_nxt;

  // Point count register.
  always_comb begin
    points_nxt = cfg_we ? cfg_wdata : points_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= 5'd2;
    end else begin
      points_r <= points_nxt;
    end
  end

  tfrl_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  tfrl_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .points_in_use (points_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_ch        (out_ch)
  );
endmodule

### src/tfrl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the result channel of the ramp lookup unit.
// ----------------------------------------------------------------------------
module tfrl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_red,
  input logic [15:0] out_green,
  input logic [15:0] out_blue,
  input logic [15:0] out_opacity
);
  // A stalled result item stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(out_opacity))
    else $error("result payload changed while stalled");

  // No result item is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // Every component is clamped to 1.0.
  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_red <= 16'd32768 && out_green <= 16'd32768 &&
      out_blue <= 16'd32768 && out_opacity <= 16'd32768)
    else $error("result component above 1.0");
endmodule

bind transfer_function_ramp_lookup_unit tfrl_checker u_tfrl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_red     (out_ch.out_red),
  .out_green   (out_ch.out_green),
  .out_blue    (out_ch.out_blue),
  .out_opacity (out_ch.out_opacity)
);
